[hw/rtl/c80alu_pkg.sv]
// Shared types and constants for the 8080 ALU block.
// Holds operation codes, the result record and the stream widths.
// No dependencies.
package c80alu_pkg;

  // Operation selector codes
  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_ADC = 4'd1,
    OP_SUB = 4'd2,
    OP_SBB = 4'd3,
    OP_ANA = 4'd4,
    OP_XRA = 4'd5,
    OP_ORA = 4'd6,
    OP_CMP = 4'd7,
    OP_INR = 4'd8,
    OP_DCR = 4'd9,
    OP_RLC = 4'd10,
    OP_RRC = 4'd11,
    OP_RAL = 4'd12,
    OP_RAR = 4'd13,
    OP_DAD = 4'd14
  } op_t;

  localparam int unsigned WordW   = 16;
  localparam int unsigned InDataW = 40;
  localparam int unsigned InUserW = 4;
  localparam int unsigned OutDataW = 24;

  // Decoded request held in the input stage
  typedef struct packed {
    op_t               req_type;
    logic [WordW-1:0]  operand_a;
    logic [WordW-1:0]  operand_b;
    logic              carry_in;
  } req_t;

  // One ALU result with its flags and update marks
  typedef struct packed {
    logic [WordW-1:0]  result;
    logic              write_back;
    logic              carry_out;
    logic              carry_updated;
    logic              aux_carry;
    logic              zero_flag;
    logic              sign_flag;
    logic              parity_flag;
    logic              szp_updated;
  } res_t;

endpackage

[hw/rtl/cpu8080_alu_flags.sv]
// Top level of the 8080 ALU: input register, ALU datapath, result register.
// The input stage registers a request, then the result register registers its ALU result.
// Throughput: one request per cycle while out_tready holds; limit is the combinational ALU.
// A new request is taken while a result waits, as long as the input stage is empty.
// Reset (rst_n low, synchronous) empties both stages; payload registers are not cleared.
// Depends on c80alu_pkg and c80alu_core.
module cpu8080_alu_flags (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  // operand_a[15:0], operand_b[31:16], carry_in[32], zero fill
  input  logic [c80alu_pkg::InDataW-1:0]  in_tdata,
  input  logic [c80alu_pkg::InUserW-1:0]  in_tuser,   // req_type[3:0]
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  // result[15:0], write_back[16], carry_out[17], carry_updated[18], aux_carry[19],
  // zero_flag[20], sign_flag[21], parity_flag[22], szp_updated[23]
  output logic [c80alu_pkg::OutDataW-1:0] out_tdata
);

  logic              s1_valid_r;
  logic              s1_valid_nxt;
  c80alu_pkg::req_t  s1_req_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  c80alu_pkg::res_t  out_res_r;
  c80alu_pkg::res_t  alu_res;
  logic              s1_advance;
  logic              in_take;

  // Input stage moves on when the result register is empty or being drained
  assign s1_advance = ~out_valid_r | out_tready;
  assign in_tready  = ~s1_valid_r | s1_advance;
  assign in_take    = in_tvalid & in_tready;

  assign s1_valid_nxt  = in_take | (s1_valid_r & ~s1_advance);
  assign out_valid_nxt = s1_advance ? s1_valid_r : out_valid_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture request payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_req_r.req_type  <= c80alu_pkg::op_t'(in_tuser);
      s1_req_r.operand_a <= in_tdata[15:0];
      s1_req_r.operand_b <= in_tdata[31:16];
      s1_req_r.carry_in  <= in_tdata[32];
    end
  end

  c80alu_core u_core (
    .req (s1_req_r),
    .res (alu_res)
  );

  // Hold result until taken
  always_ff @(posedge clk) begin
    if (s1_advance && s1_valid_r) begin
      out_res_r <= alu_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.szp_updated, out_res_r.parity_flag, out_res_r.sign_flag,
                       out_res_r.zero_flag, out_res_r.aux_carry, out_res_r.carry_updated,
                       out_res_r.carry_out, out_res_r.write_back, out_res_r.result};

  // Reset empties the result stage
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("result stage not empty after reset");

  // An accepted request always occupies the input stage next cycle
  a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> s1_valid_r)
    else $error("accepted request lost");

  // A stalled input stage keeps its request
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_advance |=> s1_valid_r && $stable(s1_req_r))
    else $error("stalled request changed");

  // Carry stays clear where the op does not update it
  a_carry_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_res_r.carry_updated |-> !out_res_r.carry_out)
    else $error("carry set on op that keeps carry");

  // Rotates, DAD and unused selectors report no zero, sign, parity or aux carry
  a_szp_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_res_r.szp_updated |->
      !out_res_r.zero_flag && !out_res_r.sign_flag &&
      !out_res_r.parity_flag && !out_res_r.aux_carry)
    else $error("flags set on op without flag update");

endmodule

[hw/rtl/c80alu_core.sv]
// Combinational 8080 ALU datapath: adders, logic ops, rotates, DAD and flags.
// Depends on c80alu_pkg for the request and result records.
module c80alu_core (
  input  c80alu_pkg::req_t req,
  output c80alu_pkg::res_t res
);

  logic [7:0]  a;
  logic [7:0]  b;
  logic [7:0]  nb;
  logic        bin;
  logic [8:0]  add_sum;
  logic [4:0]  add_nib;
  logic [8:0]  sub_sum;
  logic [4:0]  sub_nib;
  logic [16:0] dad_sum;
  logic [7:0]  byte_res;
  logic        szp;

  assign a  = req.operand_a[7:0];
  assign b  = req.operand_b[7:0];
  assign nb = ~b;

  // Carry or borrow into the adder only for ADC and SBB
  assign bin = (req.req_type == c80alu_pkg::OP_ADC || req.req_type == c80alu_pkg::OP_SBB)
               ? req.carry_in : 1'b0;

  // Shared byte adders; subtract as A + ~B + !borrow, carry out is !borrow
  assign add_sum = {1'b0, a} + {1'b0, b} + {8'd0, bin};
  assign add_nib = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, bin};
  assign sub_sum = {1'b0, a} + {1'b0, nb} + {8'd0, ~bin};
  assign sub_nib = {1'b0, a[3:0]} + {1'b0, nb[3:0]} + {4'd0, ~bin};
  assign dad_sum = {1'b0, req.operand_a} + {1'b0, req.operand_b};

  // Select result and raw flags by operation
  always_comb begin
    res      = '0;
    byte_res = '0;
    szp      = 1'b1;
    res.write_back    = 1'b1;
    res.carry_updated = 1'b1;
    case (req.req_type)
      c80alu_pkg::OP_ADD, c80alu_pkg::OP_ADC: begin
        byte_res      = add_sum[7:0];
        res.carry_out = add_sum[8];
        res.aux_carry = add_nib[4];
      end
      c80alu_pkg::OP_SUB, c80alu_pkg::OP_SBB, c80alu_pkg::OP_CMP: begin
        byte_res       = sub_sum[7:0];
        res.carry_out  = ~sub_sum[8];
        res.aux_carry  = sub_nib[4];
        res.write_back = (req.req_type != c80alu_pkg::OP_CMP);
      end
      c80alu_pkg::OP_ANA: byte_res = a & b;
      c80alu_pkg::OP_XRA: byte_res = a ^ b;
      c80alu_pkg::OP_ORA: byte_res = a | b;
      c80alu_pkg::OP_INR: begin
        byte_res          = a + 8'd1;
        res.aux_carry     = (a[3:0] == 4'hF);
        res.carry_updated = 1'b0;
      end
      c80alu_pkg::OP_DCR: begin
        byte_res          = a - 8'd1;
        res.aux_carry     = (a[3:0] != 4'h0);
        res.carry_updated = 1'b0;
      end
      c80alu_pkg::OP_RLC: begin
        byte_res      = {a[6:0], a[7]};
        res.carry_out = a[7];
        szp           = 1'b0;
      end
      c80alu_pkg::OP_RRC: begin
        byte_res      = {a[0], a[7:1]};
        res.carry_out = a[0];
        szp           = 1'b0;
      end
      c80alu_pkg::OP_RAL: begin
        byte_res      = {a[6:0], req.carry_in};
        res.carry_out = a[7];
        szp           = 1'b0;
      end
      c80alu_pkg::OP_RAR: begin
        byte_res      = {req.carry_in, a[7:1]};
        res.carry_out = a[0];
        szp           = 1'b0;
      end
      c80alu_pkg::OP_DAD: begin
        szp           = 1'b0;
        res.carry_out = dad_sum[16];
      end
      default: begin
        // unused selector: everything reads as zero
        szp               = 1'b0;
        res.write_back    = 1'b0;
        res.carry_updated = 1'b0;
      end
    endcase

    // Widen byte result, DAD keeps the full word
    if (req.req_type == c80alu_pkg::OP_DAD) begin
      res.result = dad_sum[15:0];
    end else begin
      res.result = {8'd0, byte_res};
    end

    // Zero, sign, parity and aux carry only where the op updates them
    res.szp_updated = szp;
    if (szp) begin
      res.zero_flag   = (byte_res == 8'd0);
      res.sign_flag   = byte_res[7];
      res.parity_flag = ~^byte_res;
    end else begin
      res.aux_carry   = 1'b0;
      res.zero_flag   = 1'b0;
      res.sign_flag   = 1'b0;
      res.parity_flag = 1'b0;
    end
  end

endmodule
